// ===== rtl/led_serial_command_parser_defines.svh =====
// ----------------------------------------------------------------------------
// led serial command parser assertion macros
// concurrent check wrappers on clk, with and without reset masking
// ----------------------------------------------------------------------------
`ifndef LED_SERIAL_COMMAND_PARSER_DEFINES_SVH
`define LED_SERIAL_COMMAND_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LSCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSCP_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSCP_ASSERT(name, prop, msg)
`define LSCP_ASSERT_RST(name, prop, msg)
`endif

`endif

// ===== rtl/lscp_pkg.sv =====
// ----------------------------------------------------------------------------
// lscp_pkg
// parse modes, command characters and decimal constants of the parser
// ----------------------------------------------------------------------------
package lscp_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SINGLE = 3'd1,
    MODE_RGB    = 3'd2,
    MODE_ON     = 3'd3,
    MODE_OFF    = 3'd4
  } parse_mode_t;

  localparam logic [7:0] CMD_SINGLE       = 8'h23; // '#'
  localparam logic [7:0] CMD_SINGLE_BLINK = 8'h2b; // '+'
  localparam logic [7:0] CMD_RGB          = 8'h2a; // '*'
  localparam logic [7:0] CMD_RGB_BLINK    = 8'h21; // '!'
  localparam logic [7:0] CMD_ON_TIME      = 8'h6e; // 'n'
  localparam logic [7:0] CMD_OFF_TIME     = 8'h66; // 'f'

  localparam int unsigned BUF_DEPTH = 11;

  localparam logic [3:0]  RGB_LEN    = 4'd11;
  localparam logic [3:0]  TIME_LEN   = 4'd4;
  localparam logic [15:0] DIGIT_BASE = 16'd48;
  localparam logic [15:0] FULL_LEVEL = 16'd255;
  localparam logic [15:0] W_THOUSAND = 16'd1000;
  localparam logic [15:0] W_HUNDRED  = 16'd100;
  localparam logic [15:0] W_TEN      = 16'd10;

endpackage

// ===== rtl/led_serial_command_parser.sv =====
// ----------------------------------------------------------------------------
// led_serial_command_parser
// decodes serial command characters into led color and blink settings
// ----------------------------------------------------------------------------
// One received character is taken per request and every request returns one
// result holding the current red, green and blue levels, blink enable and the
// blink on and off times. A character is decoded in the cycle it is accepted
// and the settings registers double as the result register, so the block
// takes one character per clock cycle; it holds off the input only while a
// result sits in the output register and out_stall is high. Digit bytes are
// collected in an 11 entry character buffer and the last byte of a command
// completes the decimal conversion together with the buffered ones.
`include "led_serial_command_parser_defines.svh"

module led_serial_command_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_red_level,
  output logic signed [15:0] out_green_level,
  output logic signed [15:0] out_blue_level,
  output logic               out_blink_enable,
  output logic signed [15:0] out_on_time,
  output logic signed [15:0] out_off_time
);

  lscp_pkg::parse_mode_t mode_r, mode_nxt;
  logic [3:0]  char_count_r, char_count_nxt;
  logic [7:0]  char_buffer_r [lscp_pkg::BUF_DEPTH];
  logic [15:0] red_r, red_nxt;
  logic [15:0] green_r, green_nxt;
  logic [15:0] blue_r, blue_nxt;
  logic        blink_r, blink_nxt;
  logic [15:0] on_time_r, on_time_nxt;
  logic [15:0] off_time_r, off_time_nxt;
  logic        out_valid_r;
  logic        in_acc;
  logic [3:0]  count_inc;
  logic        buf_wr;

  function automatic logic [15:0] digit(input logic [7:0] ch);
    digit = {8'd0, ch} - lscp_pkg::DIGIT_BASE;
  endfunction

  function automatic logic [15:0] dec3(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2);
    dec3 = lscp_pkg::W_HUNDRED * digit(c0) + lscp_pkg::W_TEN * digit(c1) + digit(c2);
  endfunction

  function automatic logic [15:0] dec4(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2, input logic [7:0] c3);
    dec4 = lscp_pkg::W_THOUSAND * digit(c0) + lscp_pkg::W_HUNDRED * digit(c1) +
           lscp_pkg::W_TEN * digit(c2) + digit(c3);
  endfunction

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign count_inc = char_count_r + 4'd1;

  always_comb begin
    mode_nxt       = mode_r;
    char_count_nxt = char_count_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    blue_nxt       = blue_r;
    blink_nxt      = blink_r;
    on_time_nxt    = on_time_r;
    off_time_nxt   = off_time_r;
    buf_wr         = 1'b0;
    case (mode_r)
      lscp_pkg::MODE_IDLE: begin
        case (in_rx_byte)
          lscp_pkg::CMD_SINGLE: begin
            mode_nxt  = lscp_pkg::MODE_SINGLE;
            blink_nxt = 1'b0;
          end
          lscp_pkg::CMD_SINGLE_BLINK: begin
            mode_nxt  = lscp_pkg::MODE_SINGLE;
            blink_nxt = 1'b1;
          end
          lscp_pkg::CMD_RGB: begin
            mode_nxt       = lscp_pkg::MODE_RGB;
            char_count_nxt = 4'd0;
            blink_nxt      = 1'b0;
          end
          lscp_pkg::CMD_RGB_BLINK: begin
            mode_nxt       = lscp_pkg::MODE_RGB;
            char_count_nxt = 4'd0;
            blink_nxt      = 1'b1;
          end
          lscp_pkg::CMD_ON_TIME: begin
            mode_nxt       = lscp_pkg::MODE_ON;
            char_count_nxt = 4'd0;
          end
          lscp_pkg::CMD_OFF_TIME: begin
            mode_nxt       = lscp_pkg::MODE_OFF;
            char_count_nxt = 4'd0;
          end
          default: begin
          end
        endcase
      end
      lscp_pkg::MODE_RGB: begin
        buf_wr         = 1'b1;
        char_count_nxt = count_inc;
        if (count_inc >= lscp_pkg::RGB_LEN) begin
          // last byte of the command comes straight from the input
          red_nxt   = dec3(char_buffer_r[0], char_buffer_r[1], char_buffer_r[2]);
          green_nxt = dec3(char_buffer_r[4], char_buffer_r[5], char_buffer_r[6]);
          blue_nxt  = dec3(char_buffer_r[8], char_buffer_r[9], in_rx_byte);
          mode_nxt       = lscp_pkg::MODE_IDLE;
          char_count_nxt = 4'd0;
        end
      end
      lscp_pkg::MODE_ON,
      lscp_pkg::MODE_OFF: begin
        buf_wr         = 1'b1;
        char_count_nxt = count_inc;
        if (count_inc >= lscp_pkg::TIME_LEN) begin
          if (mode_r == lscp_pkg::MODE_ON) begin
            on_time_nxt = dec4(char_buffer_r[0], char_buffer_r[1], char_buffer_r[2],
                               in_rx_byte);
          end else begin
            off_time_nxt = dec4(char_buffer_r[0], char_buffer_r[1], char_buffer_r[2],
                                in_rx_byte);
          end
          mode_nxt       = lscp_pkg::MODE_IDLE;
          char_count_nxt = 4'd0;
        end
      end
      default: begin
        // single digit; unused codes decode the same way
        red_nxt   = in_rx_byte[0] ? lscp_pkg::FULL_LEVEL : 16'd0;
        green_nxt = in_rx_byte[1] ? lscp_pkg::FULL_LEVEL : 16'd0;
        blue_nxt  = in_rx_byte[2] ? lscp_pkg::FULL_LEVEL : 16'd0;
        mode_nxt  = lscp_pkg::MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= lscp_pkg::MODE_IDLE;
      char_count_r <= 4'd0;
      red_r        <= 16'd0;
      green_r      <= 16'd0;
      blue_r       <= 16'd0;
      blink_r      <= 1'b0;
      on_time_r    <= 16'd0;
      off_time_r   <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r       <= mode_nxt;
        char_count_r <= char_count_nxt;
        red_r        <= red_nxt;
        green_r      <= green_nxt;
        blue_r       <= blue_nxt;
        blink_r      <= blink_nxt;
        on_time_r    <= on_time_nxt;
        off_time_r   <= off_time_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && buf_wr && (char_count_r < lscp_pkg::RGB_LEN)) begin
      char_buffer_r[char_count_r] <= in_rx_byte;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_level    = red_r;
  assign out_green_level  = green_r;
  assign out_blue_level   = blue_r;
  assign out_blink_enable = blink_r;
  assign out_on_time      = on_time_r;
  assign out_off_time     = off_time_r;

  `LSCP_ASSERT(a_idle_count_zero, (mode_r == lscp_pkg::MODE_IDLE) |-> (char_count_r == 4'd0), "char count not zero in idle")
  `LSCP_ASSERT(a_rgb_count_range, (mode_r == lscp_pkg::MODE_RGB) |-> (char_count_r < lscp_pkg::RGB_LEN), "rgb char count out of range")
  `LSCP_ASSERT(a_time_count_range, (mode_r == lscp_pkg::MODE_ON || mode_r == lscp_pkg::MODE_OFF) |-> (char_count_r < lscp_pkg::TIME_LEN), "time char count out of range")
  `LSCP_ASSERT(a_accept_gives_result, in_acc |=> out_valid_r, "accepted request gave no result")
  `LSCP_ASSERT(a_settings_hold, !in_acc |=> ($stable(red_r) && $stable(on_time_r) && $stable(off_time_r) && $stable(blink_r)), "settings changed without a request")
  `LSCP_ASSERT_RST(a_reset_clears_valid, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

// ===== bench/led_settings_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_settings_checker
// watches both channels of the led command parser. It keeps its own copy of
// the parser state, works out the settings that are due after each accepted
// character, and compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module led_settings_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_red_level,
  input  logic signed [15:0] out_green_level,
  input  logic signed [15:0] out_blue_level,
  input  logic               out_blink_enable,
  input  logic signed [15:0] out_on_time,
  input  logic signed [15:0] out_off_time,
  output int                 error_count,
  output int                 pending_count
);

  typedef struct packed {
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
    logic               blink;
    logic signed [15:0] on_time;
    logic signed [15:0] off_time;
  } led_settings_t;

  lscp_pkg::parse_mode_t mode;
  logic [3:0]            char_count;
  logic [7:0]            chars [lscp_pkg::BUF_DEPTH];
  led_settings_t         settings;
  led_settings_t         want;
  led_settings_t         expected_settings [$];

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic logic [15:0] decode_digits(input int first, input int n,
                                                input logic [15:0] weight);
    logic [15:0] acc;
    logic [15:0] w;
    acc = '0;
    w = weight;
    for (int i = 0; i < n; i++) begin
      acc = acc + w * ({8'd0, chars[4'(first + i)]} - lscp_pkg::DIGIT_BASE);
      w = w / lscp_pkg::W_TEN;
    end
    return acc;
  endfunction

  function automatic led_settings_t apply_char(input logic [7:0] b);
    logic [3:0] msg_len;
    logic [7:0] digit;
    case (mode)
      lscp_pkg::MODE_IDLE: begin
        case (b)
          lscp_pkg::CMD_SINGLE, lscp_pkg::CMD_SINGLE_BLINK: mode = lscp_pkg::MODE_SINGLE;
          lscp_pkg::CMD_RGB, lscp_pkg::CMD_RGB_BLINK: begin
            mode = lscp_pkg::MODE_RGB;
            char_count = '0;
          end
          lscp_pkg::CMD_ON_TIME: begin
            mode = lscp_pkg::MODE_ON;
            char_count = '0;
          end
          lscp_pkg::CMD_OFF_TIME: begin
            mode = lscp_pkg::MODE_OFF;
            char_count = '0;
          end
          default: ;
        endcase
        if (b == lscp_pkg::CMD_SINGLE_BLINK || b == lscp_pkg::CMD_RGB_BLINK) begin
          settings.blink = 1'b1;
        end else if (b == lscp_pkg::CMD_SINGLE || b == lscp_pkg::CMD_RGB) begin
          settings.blink = 1'b0;
        end
      end
      lscp_pkg::MODE_RGB, lscp_pkg::MODE_ON, lscp_pkg::MODE_OFF: begin
        msg_len = (mode == lscp_pkg::MODE_RGB) ? lscp_pkg::RGB_LEN : lscp_pkg::TIME_LEN;
        if (char_count < lscp_pkg::RGB_LEN) begin
          chars[char_count] = b;
        end
        char_count = char_count + 4'd1;
        if (char_count >= msg_len) begin
          case (mode)
            lscp_pkg::MODE_RGB: begin
              settings.red   = decode_digits(0, 3, lscp_pkg::W_HUNDRED);
              settings.green = decode_digits(4, 3, lscp_pkg::W_HUNDRED);
              settings.blue  = decode_digits(8, 3, lscp_pkg::W_HUNDRED);
            end
            lscp_pkg::MODE_ON: settings.on_time = decode_digits(0, 4, lscp_pkg::W_THOUSAND);
            default: settings.off_time = decode_digits(0, 4, lscp_pkg::W_THOUSAND);
          endcase
          mode = lscp_pkg::MODE_IDLE;
          char_count = '0;
        end
      end
      default: begin
        // single digit, and any stray mode code
        digit = b - lscp_pkg::DIGIT_BASE[7:0];
        settings.red   = digit[0] ? lscp_pkg::FULL_LEVEL : '0;
        settings.green = digit[1] ? lscp_pkg::FULL_LEVEL : '0;
        settings.blue  = digit[2] ? lscp_pkg::FULL_LEVEL : '0;
        mode = lscp_pkg::MODE_IDLE;
      end
    endcase
    return settings;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode = lscp_pkg::MODE_IDLE;
      char_count = '0;
      settings = '0;
      expected_settings.delete();
      error_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_settings.push_back(apply_char(in_rx_byte));
      end
      if (out_valid && !out_stall) begin
        if (expected_settings.size() == 0) begin
          report("result with no request pending");
        end else begin
          want = expected_settings.pop_front();
          if (out_red_level !== want.red)
            report($sformatf("red_level %0d, expected %0d", out_red_level, want.red));
          if (out_green_level !== want.green)
            report($sformatf("green_level %0d, expected %0d", out_green_level, want.green));
          if (out_blue_level !== want.blue)
            report($sformatf("blue_level %0d, expected %0d", out_blue_level, want.blue));
          if (out_blink_enable !== want.blink)
            report($sformatf("blink_enable %0b, expected %0b", out_blink_enable, want.blink));
          if (out_on_time !== want.on_time)
            report($sformatf("on_time %0d, expected %0d", out_on_time, want.on_time));
          if (out_off_time !== want.off_time)
            report($sformatf("off_time %0d, expected %0d", out_off_time, want.off_time));
        end
      end
    end
    pending_count = expected_settings.size();
  end

endmodule

// ===== bench/tb_led_serial_command_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_serial_command_parser
// feeds the led command parser a short directed set of commands, then
// mostly well-formed random commands with random digits and some noise,
// under three pacing phases of sender gaps and receiver stalls. Checking is
// done by the settings checker; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_led_serial_command_parser;

  localparam int QUIET_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_red_level;
  logic signed [15:0] out_green_level;
  logic signed [15:0] out_blue_level;
  logic               out_blink_enable;
  logic signed [15:0] out_on_time;
  logic signed [15:0] out_off_time;

  int error_count;
  int pending_count;
  int send_idle_pct = 10;
  int recv_stall_pct = 73;
  int requests_sent = 0;
  int quiet_cycles = 0;

  led_serial_command_parser uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red_level    (out_red_level),
    .out_green_level  (out_green_level),
    .out_blue_level   (out_blue_level),
    .out_blink_enable (out_blink_enable),
    .out_on_time      (out_on_time),
    .out_off_time     (out_off_time)
  );

  led_settings_checker settings_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red_level    (out_red_level),
    .out_green_level  (out_green_level),
    .out_blue_level   (out_blue_level),
    .out_blink_enable (out_blink_enable),
    .out_on_time      (out_on_time),
    .out_off_time     (out_off_time),
    .error_count      (error_count),
    .pending_count    (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // mostly decimal digits, now and then any byte
  function automatic logic [7:0] digit_char();
    logic [7:0] c;
    if ($urandom_range(15) == 0) begin
      c = 8'($urandom_range(255));
    end else begin
      c = lscp_pkg::DIGIT_BASE[7:0] + 8'($urandom_range(9));
    end
    return c;
  endfunction

  task automatic send_random_command();
    int kind;
    logic [7:0] noise;
    kind = int'($urandom_range(9));
    if (kind < 2) begin
      send_byte($urandom_range(1) ? lscp_pkg::CMD_SINGLE : lscp_pkg::CMD_SINGLE_BLINK);
      send_byte(digit_char());
    end else if (kind < 5) begin
      send_byte($urandom_range(1) ? lscp_pkg::CMD_RGB : lscp_pkg::CMD_RGB_BLINK);
      repeat (lscp_pkg::RGB_LEN) send_byte(digit_char());
    end else if (kind < 8) begin
      send_byte($urandom_range(1) ? lscp_pkg::CMD_ON_TIME : lscp_pkg::CMD_OFF_TIME);
      repeat (lscp_pkg::TIME_LEN) send_byte(digit_char());
    end else begin
      noise = 8'($urandom_range(255));
      send_byte(noise);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ignored byte, single digit with extreme bytes
    send_byte(8'h00);
    send_byte(lscp_pkg::CMD_SINGLE_BLINK);
    send_byte(8'hff);
    send_byte(lscp_pkg::CMD_SINGLE);
    send_text("5");
    // rgb with separators, then times at both ends and with non-digits
    send_byte(lscp_pkg::CMD_RGB_BLINK);
    send_text("255x128x009");
    send_byte(lscp_pkg::CMD_ON_TIME);
    send_text("9999");
    send_byte(lscp_pkg::CMD_OFF_TIME);
    send_byte(8'hff);
    send_byte(8'h00);
    send_text("9z");

    while (requests_sent < 190) send_random_command();
    send_idle_pct = 73;
    recv_stall_pct = 10;
    while (requests_sent < 360) send_random_command();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (requests_sent < 530) send_random_command();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
